// ===== hdl/dfs_pkg.sv =====
// Shared types and constants for the five-point diffusion stencil.
// No dependencies; used by dfs_line_mem and diffusion_stencil_5pt.
package dfs_pkg;

  localparam int CELL_W = 16;
  localparam int FACTOR_W = 16;
  localparam int TILE_W = 7;

  localparam int MAX_TILE_DEF = 64;
  localparam int TILE_MIN = 2;

  localparam logic [FACTOR_W-1:0] FACTOR_RST = 16'd13107;
  localparam logic [TILE_W-1:0] TILE_RST = 7'd64;

  // APB register map
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_FACTOR = 1'b0;
  localparam logic REG_TILE = 1'b1;

  typedef logic signed [CELL_W-1:0] cell_t;

  // One column of the two line stores: padded rows r-2 (upper) and r-1 (middle)
  typedef struct packed {
    cell_t upper;
    cell_t middle;
  } line_word_t;

endpackage

// ===== hdl/dfs_line_mem.sv =====
// Line store RAM: one word per padded column, holding the upper and middle rows.
// One write port, one read port with registered, write-through read data.
// Depends on dfs_pkg.
module dfs_line_mem #(
  parameter int DEPTH = dfs_pkg::MAX_TILE_DEF + 2,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [ADDR_W-1:0]       wr_addr,
  input  dfs_pkg::line_word_t     wr_data,
  input  logic                    rd_en,
  input  logic [ADDR_W-1:0]       rd_addr,
  output dfs_pkg::line_word_t     rd_data
);

  dfs_pkg::line_word_t mem [DEPTH];
  dfs_pkg::line_word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // pass a same-cycle write through to the reader
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/diffusion_stencil_5pt.sv =====
// Five-point explicit Euler diffusion stencil, top level.
// Depends on dfs_pkg and dfs_line_mem.
//
// Cells of a square tile with a one-cell ghost border stream in on the in_
// channel in raster order, (tile_size+2) x (tile_size+2) cells per tile, one
// transfer per clock at full rate. Each interior cell is replaced by
// c + factor*(n+s+e+w-4c) in signed Q2.14 (factor unsigned Q0.16, product
// rounded to nearest with ties upward, sum saturated) and is sent out once the
// cell directly below it has been taken in; out_row/out_col give its interior
// position and out_last_of_tile marks the bottom-right interior cell.
// Throughput is one cell per cycle unless out_ready stalls it; after the
// transfer of its south neighbor a result passes the line-store read/window
// stage, the multiply stage and the output register. The upper and middle
// line stores share one (MAX_TILE+2) x 32 RAM with one write and one read port;
// the two extra writes at the end of a row are drained from a two-entry queue
// on write-free cycles, which the row-start cells always provide. The line
// stores are not cleared after reset: interior results depend on rows that
// have streamed in since. tile_start forces the cell to padded position (0,0);
// without it the position wraps at the end of each tile on its own. Registers
// (APB, byte address 4*i): 0 stencil_factor, 1 tile_size (clamped to
// 2..MAX_TILE). Write registers only while no transfer is in flight.
module diffusion_stencil_5pt #(
  parameter int MAX_TILE = dfs_pkg::MAX_TILE_DEF,
  localparam int POS_W = $clog2(MAX_TILE + 2),
  localparam int ROW_W = $clog2(MAX_TILE + 1)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  dfs_pkg::cell_t                      in_cell_value,
  input  logic                                in_tile_start,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output dfs_pkg::cell_t                      out_new_value,
  output logic [ROW_W-1:0]                    out_row,
  output logic [ROW_W-1:0]                    out_col,
  output logic                                out_last_of_tile,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dfs_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [dfs_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [dfs_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready
);

  localparam int LINE_DEPTH = MAX_TILE + 2;
  localparam int LAP_W = dfs_pkg::CELL_W + 3;
  localparam int PROD_W = dfs_pkg::FACTOR_W + 1 + LAP_W;
  localparam int Q_W = PROD_W + 1;
  localparam int FRAC_W = dfs_pkg::FACTOR_W;
  localparam int RND_W = Q_W - FRAC_W;
  localparam int SUM_W = RND_W + 1;
  localparam logic signed [Q_W-1:0] ROUND_HALF = Q_W'(32768);
  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(32767);
  localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(32768);
  localparam logic [POS_W-1:0] POS_ONE = POS_W'(1);
  localparam logic [POS_W-1:0] POS_TWO = POS_W'(2);

  typedef struct packed {
    logic [POS_W-1:0]    addr;
    dfs_pkg::line_word_t data;
  } line_wr_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [dfs_pkg::FACTOR_W-1:0] factor_r;
  logic [dfs_pkg::TILE_W-1:0]   tile_size_r;
  logic                         cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r    <= dfs_pkg::FACTOR_RST;
      tile_size_r <= dfs_pkg::TILE_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        dfs_pkg::REG_FACTOR: factor_r <= pwdata[dfs_pkg::FACTOR_W-1:0];
        dfs_pkg::REG_TILE:   tile_size_r <= pwdata[dfs_pkg::TILE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      dfs_pkg::REG_FACTOR: prdata = dfs_pkg::APB_DATA_W'(factor_r);
      dfs_pkg::REG_TILE:   prdata = dfs_pkg::APB_DATA_W'(tile_size_r);
      default:             prdata = '0;
    endcase
  end

  // Last padded row/column index: clamped tile size plus one
  logic [POS_W-1:0] last_pos;

  always_comb begin
    if (int'(tile_size_r) < dfs_pkg::TILE_MIN) begin
      last_pos = POS_W'(dfs_pkg::TILE_MIN + 1);
    end else if (int'(tile_size_r) > MAX_TILE) begin
      last_pos = POS_W'(MAX_TILE + 1);
    end else begin
      last_pos = POS_W'(int'(tile_size_r) + 1);
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake chain: input -> S (window) -> P (multiply) -> output register
  // ---------------------------------------------------------------------------
  logic s_valid_r, p_valid_r, p_res_r, out_valid_r;
  logic o_free, p_go, p_free, s_go, in_xfer;

  assign o_free   = !out_valid_r || out_ready;
  assign p_go     = p_valid_r && (!p_res_r || o_free);
  assign p_free   = !p_valid_r || p_go;
  assign s_go     = s_valid_r && p_free;
  assign in_ready = !s_valid_r || s_go;
  assign in_xfer  = in_valid && in_ready;

  // ---------------------------------------------------------------------------
  // Padded position of the incoming cell
  // ---------------------------------------------------------------------------
  logic [POS_W-1:0] row_r, col_r, row_nxt, col_nxt;
  logic [POS_W-1:0] in_row, in_col;

  assign in_row = in_tile_start ? '0 : row_r;
  assign in_col = in_tile_start ? '0 : col_r;

  always_comb begin
    row_nxt = in_row;
    col_nxt = in_col + POS_ONE;
    // end of row, and wrap to the top at the end of the tile
    if (in_col >= last_pos) begin
      col_nxt = '0;
      row_nxt = (in_row >= last_pos) ? '0 : in_row + POS_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (in_xfer) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage S: cell, its position, line-store word at its column, and a window
  // of the two previous cells and their line-store words
  // ---------------------------------------------------------------------------
  dfs_pkg::cell_t      s_x_r;
  logic [POS_W-1:0]    s_row_r, s_col_r;
  dfs_pkg::line_word_t rd_word;
  dfs_pkg::cell_t      win0_r, win1_r;
  dfs_pkg::line_word_t m1_r, m2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s_valid_r <= 1'b1;
    end else if (s_go) begin
      s_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s_x_r   <= in_cell_value;
      s_row_r <= in_row;
      s_col_r <= in_col;
    end
    // shift the window as the cell leaves S
    if (s_go) begin
      win0_r <= s_x_r;
      win1_r <= win0_r;
      m1_r   <= rd_word;
      m2_r   <= m1_r;
    end
  end

  logic s_res, s_row_ok, s_col_ok, s_col_wr, s_row_end;
  logic [POS_W-1:0] s_row_m1, s_col_m1, s_col_m2;

  assign s_row_ok  = (s_row_r >= POS_TWO) && (s_row_r <= last_pos);
  assign s_col_ok  = (s_col_r >= POS_TWO) && (s_col_r <= last_pos);
  assign s_res     = s_row_ok && s_col_ok;
  assign s_col_wr  = s_go && s_col_ok;
  assign s_row_end = s_go && (s_col_r == last_pos);
  assign s_row_m1  = s_row_r - POS_ONE;
  assign s_col_m1  = s_col_r - POS_ONE;
  assign s_col_m2  = s_col_r - POS_TWO;

  // Laplacian: north upper[c-1], south previous cell, east/west/center middle
  logic signed [LAP_W-1:0] s_lap;

  assign s_lap = LAP_W'(m1_r.upper) + LAP_W'(win0_r) + LAP_W'(rd_word.middle)
               + LAP_W'(m2_r.middle) - (LAP_W'(m1_r.middle) <<< 2);

  // ---------------------------------------------------------------------------
  // Line-store writes: column c-2 on each cell from column 2 to the last,
  // columns c-1 and c queued at the end of a row; each write pushes middle
  // down into upper
  line_wr_t pend_a_r, pend_b_r;
  logic     pend_a_v_r, pend_b_v_r;
  logic     mem_we;
  line_wr_t mem_wr;

  always_comb begin
    mem_we = 1'b0;
    mem_wr = pend_a_r;
    if (s_col_wr) begin
      mem_we             = 1'b1;
      mem_wr.addr        = s_col_m2;
      mem_wr.data.upper  = m2_r.middle;
      mem_wr.data.middle = win1_r;
    end else if (pend_a_v_r) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_a_v_r <= 1'b0;
      pend_b_v_r <= 1'b0;
    end else if (s_row_end) begin
      pend_a_v_r <= 1'b1;
      pend_b_v_r <= 1'b1;
    end else if (!s_col_wr && pend_a_v_r) begin
      pend_a_v_r <= pend_b_v_r;
      pend_b_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_row_end) begin
      pend_a_r.addr        <= s_col_m1;
      pend_a_r.data.upper  <= m1_r.middle;
      pend_a_r.data.middle <= win0_r;
      pend_b_r.addr        <= s_col_r;
      pend_b_r.data.upper  <= rd_word.middle;
      pend_b_r.data.middle <= s_x_r;
    end else if (!s_col_wr && pend_a_v_r) begin
      pend_a_r <= pend_b_r;
    end
  end

  dfs_line_mem #(
    .DEPTH(LINE_DEPTH)
  ) u_line_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_wr.addr),
    .wr_data (mem_wr.data),
    .rd_en   (in_xfer),
    .rd_addr (in_col),
    .rd_data (rd_word)
  );

  // ---------------------------------------------------------------------------
  // Stage P: scale, round and saturate
  // ---------------------------------------------------------------------------
  logic signed [LAP_W-1:0] p_lap_r;
  dfs_pkg::cell_t          p_center_r;
  logic [ROW_W-1:0]        p_row_r, p_col_r;
  logic                    p_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (s_go) begin
      p_valid_r <= 1'b1;
    end else if (p_go) begin
      p_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_go) begin
      p_res_r    <= s_res;
      p_lap_r    <= s_lap;
      p_center_r <= m1_r.middle;
      p_row_r    <= s_row_m1[ROW_W-1:0];
      p_col_r    <= s_col_m1[ROW_W-1:0];
      p_last_r   <= (s_row_r == last_pos) && (s_col_r == last_pos);
    end
  end

  logic signed [PROD_W-1:0] p_prod;
  logic signed [Q_W-1:0]    p_q;
  logic signed [RND_W-1:0]  p_rnd;
  logic signed [SUM_W-1:0]  p_sum;
  dfs_pkg::cell_t           p_new;

  assign p_prod = $signed({1'b0, factor_r}) * p_lap_r;
  // round half up: add one half LSB of Q2.14, then floor
  assign p_q    = Q_W'(p_prod) + ROUND_HALF;
  assign p_rnd  = p_q[Q_W-1:FRAC_W];
  assign p_sum  = SUM_W'(p_rnd) + SUM_W'(p_center_r);

  always_comb begin
    if (p_sum > SAT_MAX) begin
      p_new = SAT_MAX[dfs_pkg::CELL_W-1:0];
    end else if (p_sum < SAT_MIN) begin
      p_new = SAT_MIN[dfs_pkg::CELL_W-1:0];
    end else begin
      p_new = p_sum[dfs_pkg::CELL_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  dfs_pkg::cell_t   out_value_r;
  logic [ROW_W-1:0] out_row_r, out_col_r;
  logic             out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (p_go && p_res_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_go && p_res_r) begin
      out_value_r <= p_new;
      out_row_r   <= p_row_r;
      out_col_r   <= p_col_r;
      out_last_r  <= p_last_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_new_value    = out_value_r;
  assign out_row          = out_row_r;
  assign out_col          = out_col_r;
  assign out_last_of_tile = out_last_r;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for diffusion_stencil_5pt: padded tiles stream in,
// each interior update is predicted in a scoreboard and compared on transfer.
// Depends on dfs_pkg and the diffusion_stencil_5pt RTL only.
module tb;

  localparam int POS_BITS = $clog2(dfs_pkg::MAX_TILE_DEF + 1);
  localparam int LINE_D = dfs_pkg::MAX_TILE_DEF + 2;
  localparam int DRAIN_TAIL = 8;        // result pipeline is three deep; pad it

  typedef enum {PACE_FULL, PACE_SPARSE, PACE_RANDOM} pace_t;

  typedef struct {
    dfs_pkg::cell_t      value;
    logic [POS_BITS-1:0] row;
    logic [POS_BITS-1:0] col;
    logic                last;
  } update_t;

  // Scoreboard: mirrors the line stores, the two-cell window of the current
  // row and the padded position, and queues the update each cell releases.
  class diffusion_checker_t;
    int unsigned factor;
    int unsigned tile_reg;
    int          upper_line[LINE_D];
    int          middle_line[LINE_D];
    int          west1, west2;          // current row at columns c-1 and c-2
    int unsigned row_at, col_at;
    update_t     due_updates[$];
    int          failures;

    function new();
      factor   = dfs_pkg::FACTOR_RST;
      tile_reg = dfs_pkg::TILE_RST;
      foreach (upper_line[i]) begin
        upper_line[i]  = 0;
        middle_line[i] = 0;
      end
      west1     = 0;
      west2     = 0;
      row_at    = 0;
      col_at    = 0;
      failures  = 0;
    endfunction

    function void write_register(logic idx, logic [31:0] data);
      if (idx == dfs_pkg::REG_FACTOR) factor = data[dfs_pkg::FACTOR_W-1:0];
      else tile_reg = data[dfs_pkg::TILE_W-1:0];
    endfunction

    function int unsigned edge_cells();
      if (tile_reg < dfs_pkg::TILE_MIN) return dfs_pkg::TILE_MIN;
      if (tile_reg > dfs_pkg::MAX_TILE_DEF) return dfs_pkg::MAX_TILE_DEF;
      return tile_reg;
    endfunction

    function int pending();
      return due_updates.size();
    endfunction

    function void shift_line(int unsigned idx, int v);
      if (idx < LINE_D) begin
        upper_line[idx]  = middle_line[idx];
        middle_line[idx] = v;
      end
    endfunction

    // One Euler step: c + factor*lap, product rounded half-up, sum saturated.
    function dfs_pkg::cell_t diffuse(int n, int s, int e, int w, int c);
      longint lap, q, r;
      lap = longint'(n) + s + e + w - 4 * longint'(c);
      q   = longint'(factor) * lap + 32768;
      r   = (q >>> 16) + c;
      if (r > 32767) r = 32767;
      else if (r < -32768) r = -32768;
      return dfs_pkg::cell_t'(r);
    endfunction

    function void take_cell(dfs_pkg::cell_t x_in, logic start);
      int unsigned last, r, c;
      int          x;
      update_t     u;
      last = edge_cells() + 1;
      x    = x_in;
      if (start) begin
        row_at = 0;
        col_at = 0;
      end
      r = row_at;
      c = col_at;
      // The cell below an interior cell releases that cell's update.
      if (r >= 2 && r <= last && c >= 2 && c <= last) begin
        u.value = diffuse(upper_line[c-1], west1, middle_line[c], middle_line[c-2],
                          middle_line[c-1]);
        u.row   = POS_BITS'(r - 1);
        u.col   = POS_BITS'(c - 1);
        u.last  = (r == last && c == last);
        due_updates.push_back(u);
      end
      if (c <= last) begin
        if (c >= 2) shift_line(c - 2, west2);
        if (c == last) begin
          shift_line(c - 1, west1);
          shift_line(c, x);
        end
      end
      west2 = west1;
      west1 = x;
      // Wrap at or past the border of the current tile size.
      if (c >= last) begin
        col_at = 0;
        row_at = (r >= last) ? 0 : r + 1;
      end else begin
        col_at = c + 1;
      end
    endfunction

    function void check_update(dfs_pkg::cell_t v, logic [POS_BITS-1:0] row,
                               logic [POS_BITS-1:0] col, logic last);
      update_t e;
      if (due_updates.size() == 0) begin
        $error("unexpected update: new_value %0d row %0d col %0d", v, row, col);
        failures++;
        return;
      end
      e = due_updates.pop_front();
      if (v !== e.value) begin
        $error("new_value: expected %0d, actual %0d", e.value, v);
        failures++;
      end
      if (row !== e.row) begin
        $error("out_row: expected %0d, actual %0d", e.row, row);
        failures++;
      end
      if (col !== e.col) begin
        $error("out_col: expected %0d, actual %0d", e.col, col);
        failures++;
      end
      if (last !== e.last) begin
        $error("last_of_tile: expected %0b, actual %0b", e.last, last);
        failures++;
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  dfs_pkg::cell_t                 in_cell_value = '0;
  logic                           in_tile_start = 1'b0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  dfs_pkg::cell_t                 out_new_value;
  logic [POS_BITS-1:0]            out_row;
  logic [POS_BITS-1:0]            out_col;
  logic                           out_last_of_tile;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [dfs_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [dfs_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [dfs_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  diffusion_checker_t board = new();
  pace_t source_pace = PACE_RANDOM;
  pace_t sink_pace = PACE_RANDOM;
  int    stall_request = 0;          // one-shot long hold-off for the result side

  diffusion_stencil_5pt uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cell_value    (in_cell_value),
    .in_tile_start    (in_tile_start),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_new_value    (out_new_value),
    .out_row          (out_row),
    .out_col          (out_col),
    .out_last_of_tile (out_last_of_tile),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle cycles before the next transfer on either side.
  function automatic int draw_gap(pace_t p);
    case (p)
      PACE_FULL: return 0;
      PACE_SPARSE: return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 19) : 0;
      default: return $urandom_range(0, 19);
    endcase
  endfunction

  // Mostly full-range noise, with rail values and small smooth values mixed in.
  function automatic dfs_pkg::cell_t random_cell();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2, 3: return dfs_pkg::cell_t'($urandom_range(0, 4095) - 2048);
      default: return dfs_pkg::cell_t'($urandom);
    endcase
  endfunction

  // Offer one cell; hold valid and payload until the transfer, then record it.
  // Valid stays high into the next call so back-to-back cells need no bubble.
  task automatic send_cell(input dfs_pkg::cell_t v, input logic start);
    int gap;
    gap = draw_gap(source_pace);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cell_value <= v;
    in_tile_start <= start;
    do @(posedge clk); while (!in_ready);
    board.take_cell(v, start);
  endtask

  // Drop valid and wait until every update has arrived, then let the
  // pipeline empty out in case the last cells were ghost cells.
  task automatic settle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  // APB write: setup phase, access phase until pready, then back to idle.
  task automatic write_reg(input logic idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.write_register(idx, data);
    @(posedge clk);
  endtask

  // Program both registers and pick fresh pacing for the next phase.
  // With junk set, the unused upper data bits carry random noise.
  task automatic configure(input int unsigned factor, input int unsigned tile,
                           input bit junk);
    logic [31:0] fw, tw, junk_w;
    fw = factor;
    tw = tile;
    if (junk) begin
      junk_w = $urandom;
      fw     = {junk_w[31:dfs_pkg::FACTOR_W], fw[dfs_pkg::FACTOR_W-1:0]};
      junk_w = $urandom;
      tw     = {junk_w[31:dfs_pkg::TILE_W], tw[dfs_pkg::TILE_W-1:0]};
    end
    write_reg(dfs_pkg::REG_FACTOR, fw);
    write_reg(dfs_pkg::REG_TILE, tw);
    source_pace = pace_t'($urandom_range(0, 2));
    sink_pace   = pace_t'($urandom_range(0, 2));
  endtask

  // Stream random tiles of the current size. With breaks, some tiles are cut
  // short by an early tile_start and some full tiles rely on the position
  // wrapping by itself; without breaks the cells simply continue the tile.
  task automatic stream_tiles(input int count, input bit mark_first, input bit breaks);
    int unsigned span, len;
    int          sent, k;
    bit          mark;
    span = (board.edge_cells() + 2) * (board.edge_cells() + 2);
    sent = 0;
    mark = mark_first;
    while (sent < count) begin
      len = span;
      if (breaks && $urandom_range(0, 5) == 0) len = $urandom_range(1, span - 1);
      for (k = 0; k < len && sent < count; k++) begin
        send_cell(random_cell(), (k == 0) && mark);
        sent++;
      end
      mark = breaks && (len < span || $urandom_range(0, 4) != 0);
    end
  endtask

  // Result side: draw a gap per transfer, or serve a pending long hold-off.
  initial begin : result_sink
    int gap;
    @(posedge clk);
    forever begin
      gap = draw_gap(sink_pace);
      if (stall_request > 0) begin
        gap           = stall_request;
        stall_request = 0;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      board.check_update(out_new_value, out_row, out_col, out_last_of_tile);
    end
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    // Rail values around the four interior cells of the smallest tile: one
    // update saturates high, two saturate low.
    dfs_pkg::cell_t rail_tile [16];

    rail_tile = '{
      16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000,
      16'sh7FFF, 16'sh8000, 16'sh0001, 16'sh8000,
      16'sh8000, 16'sh0000, 16'sh7FFF, 16'sh8000,
      16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: full-scale factor on a 2x2 interior.
    configure(16'hFFFF, dfs_pkg::TILE_MIN, 1'b0);
    foreach (rail_tile[i]) send_cell(rail_tile[i], i == 0);
    settle();

    // Half factor: every odd Laplacian lands exactly on a rounding tie.
    configure(32768, 3, 1'b0);
    stream_tiles(200, 1'b1, 1'b1);
    settle();

    // Zero factor passes the center through; size 0 acts as the minimum.
    configure(0, 0, 1'b0);
    stream_tiles(100, 1'b1, 1'b1);
    settle();

    configure(1, 1, 1'b0);
    stream_tiles(60, 1'b1, 1'b1);
    settle();

    // Hold the result side off for a long stretch while cells keep coming,
    // so the block backs up and stalls its input.
    configure(dfs_pkg::FACTOR_RST, 5, 1'b0);
    source_pace   = PACE_FULL;
    stall_request = 300;
    stream_tiles(200, 1'b1, 1'b1);
    settle();

    // Shrink the tile in the middle of one and carry on without tile_start:
    // positions past the new border wrap.
    configure(16384, 8, 1'b0);
    stream_tiles(145, 1'b1, 1'b1);
    settle();
    write_reg(dfs_pkg::REG_TILE, 3);
    stream_tiles(120, 1'b0, 1'b1);
    settle();

    configure($urandom_range(16385, 65535), 7, 1'b0);
    stream_tiles(200, 1'b1, 1'b1);
    settle();

    configure($urandom_range(0, 65535), $urandom_range(2, 12), 1'b1);
    stream_tiles(200, 1'b1, 1'b1);
    settle();

    // First rows of a tile at the largest size (127 clamps to the maximum);
    // stall the result side partway, and pause the input until all updates
    // are in.
    configure($urandom_range(0, 16384), 127, 1'b0);
    if (source_pace == PACE_RANDOM) source_pace = PACE_SPARSE;
    stream_tiles(100, 1'b1, 1'b0);
    source_pace   = PACE_FULL;
    stall_request = 500;
    stream_tiles(100, 1'b0, 1'b0);

    settle();
    if (board.failures == 0 && board.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
